// ===== rtl/lsrm_pkg.sv =====
// Package for the limit switch reversing motor unit.
// Holds the opcode, drive state and register index codes and the pin struct.
// No dependencies.
package lsrm_pkg;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned TargetW  = 15;
  localparam int unsigned CountW   = 16;

  // Opcodes carried by an input item; the unused code behaves as a stop.
  localparam logic [1:0] OP_STOP        = 2'd0;
  localparam logic [1:0] OP_RUN         = 2'd1;
  localparam logic [1:0] OP_RUN_LIMITED = 2'd2;

  // Drive states, also used as the travel direction flag (brake means none).
  localparam logic [1:0] DRV_BRAKE = 2'd0;
  localparam logic [1:0] DRV_REV   = 2'd1;
  localparam logic [1:0] DRV_FWD   = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_CYCLE_TARGET  = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_STALL_TIMEOUT = 1'b1;

  localparam logic [CountW-1:0] STALL_TIMEOUT_RST = 16'd4000;
  localparam logic [CountW-1:0] COUNT_MAX         = 16'hFFFF;

  typedef struct packed {
    logic en;
    logic dir;
    logic run;
  } pins_t;

endpackage

// ===== rtl/lsrm_if.sv =====
// Channel interfaces of the limit switch reversing motor unit.
// Depends on lsrm_pkg for the payload widths.
interface lsrm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic       start_forward;
  logic       left_sensor_high;
  logic       right_sensor_high;

  modport source (output valid, opcode, start_forward, left_sensor_high,
                  right_sensor_high, input ready);
  modport sink (input valid, opcode, start_forward, left_sensor_high,
                right_sensor_high, output ready);
endinterface

interface lsrm_out_if;
  logic        valid;
  logic        ready;
  logic        enable_pin;
  logic        direction_pin;
  logic        run_pin;
  logic        done_res;
  logic [1:0]  travel_direction;
  logic [15:0] sweep_count;

  modport source (output valid, enable_pin, direction_pin, run_pin, done_res,
                  travel_direction, sweep_count, input ready);
  modport sink (input valid, enable_pin, direction_pin, run_pin, done_res,
                travel_direction, sweep_count, output ready);
endinterface

interface lsrm_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [lsrm_pkg::CfgIdxW-1:0]  index;
  logic [lsrm_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/limit_switch_reversing_motor_unit.sv =====
// Top level of the limit switch reversing motor unit.
// Depends on lsrm_pkg and the channel interfaces in lsrm_if.sv.

// Back-and-forth motor sequencer. Each input item is one tick: an opcode
// (stop, run, run until the sweep target is reached), a start direction and
// the two end-stop sensor levels. Every item yields exactly one result item
// with the three drive pin levels, a done flag, the travel direction and the
// reversal count. The unit takes one item per clock cycle; the result
// appears in the output register in the cycle after the item is accepted. The
// whole tick decision is a single pass of compares and 16-bit counter
// updates, and the only thing that holds the input back is a full output
// register whose item is not being taken in the same cycle. The
// configuration port is always ready; cycle_target and stall_timeout are to
// be written only while no item is in flight.
module limit_switch_reversing_motor_unit
  import lsrm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  lsrm_in_if.sink     in_i,
  lsrm_out_if.source  out_o,
  lsrm_cfg_if.sink    cfg_i
);

  // Configuration registers.
  logic [TargetW-1:0] cycle_target_q;
  logic [CountW-1:0]  stall_timeout_q;

  // Sequencer state.
  logic              running_q, running_d;
  logic [1:0]        dir_flag_q, dir_flag_d;
  logic [1:0]        last_drive_q, last_drive_d;
  logic [CountW-1:0] stall_q, stall_d;
  logic [CountW-1:0] rev_q, rev_d;
  pins_t             pins_q, pins_d;

  // Output register.
  logic              out_valid_q;
  logic              done_q, done_d;

  logic              in_acc;
  logic              out_acc;

  assign cfg_i.ready = 1'b1;

  // A new item is taken whenever the output register is empty or drains now.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_valid_q && out_o.ready;

  always_comb begin
    logic [CountW-1:0] limit;
    logic [CountW-1:0] stall_inc;
    logic [1:0]        start_dir;
    logic [1:0]        req;
    logic              do_run;
    logic              do_stop;

    running_d    = running_q;
    dir_flag_d   = dir_flag_q;
    last_drive_d = last_drive_q;
    stall_d      = stall_q;
    rev_d        = rev_q;
    pins_d       = pins_q;
    done_d       = 1'b0;
    req          = last_drive_q;
    do_run       = 1'b0;
    do_stop      = 1'b0;

    limit     = {cycle_target_q, 1'b0};
    stall_inc = stall_q + 16'd1;
    start_dir = in_i.start_forward ? DRV_FWD : DRV_REV;

    case (in_i.opcode)
      OP_RUN: begin
        do_run = 1'b1;
      end
      OP_RUN_LIMITED: begin
        // Target reached: pin the count at the limit and stop, every time.
        if (rev_q >= limit) begin
          rev_d   = limit;
          do_stop = 1'b1;
          done_d  = 1'b1;
        end else begin
          do_run = 1'b1;
        end
      end
      default: begin
        do_stop = 1'b1;
      end
    endcase

    if (do_stop) begin
      req       = DRV_BRAKE;
      running_d = 1'b0;
    end

    if (do_run) begin
      if (!running_q) begin
        // First run tick after a stop ignores the sensors.
        req        = start_dir;
        running_d  = 1'b1;
        dir_flag_d = start_dir;
      end else begin
        if (!in_i.left_sensor_high && in_i.right_sensor_high) begin
          if (dir_flag_q != DRV_FWD) begin
            dir_flag_d = DRV_FWD;
            stall_d    = '0;
          end
        end else if (in_i.left_sensor_high && !in_i.right_sensor_high) begin
          if (dir_flag_q != DRV_REV) begin
            dir_flag_d = DRV_REV;
            stall_d    = '0;
          end
        end else if (in_i.left_sensor_high && in_i.right_sensor_high) begin
          // Both sensors high counts as a stall; time out into forward.
          stall_d = stall_inc;
          if (dir_flag_q != DRV_FWD && stall_inc >= stall_timeout_q) begin
            stall_d    = '0;
            dir_flag_d = DRV_FWD;
          end
        end
        req = dir_flag_d;
      end
    end

    // Pins move only on a change of drive state; a reverse/forward swap
    // counts one reversal, saturating at the top of the counter.
    if (req != last_drive_q) begin
      case (req)
        DRV_REV: begin
          pins_d.en  = 1'b1;
          pins_d.run = 1'b1;
          pins_d.dir = 1'b0;
          if (last_drive_q == DRV_FWD && rev_d != COUNT_MAX) begin
            rev_d = rev_d + 16'd1;
          end
          last_drive_d = DRV_REV;
        end
        DRV_FWD: begin
          pins_d.en  = 1'b1;
          pins_d.run = 1'b1;
          pins_d.dir = 1'b1;
          if (last_drive_q == DRV_REV && rev_d != COUNT_MAX) begin
            rev_d = rev_d + 16'd1;
          end
          last_drive_d = DRV_FWD;
        end
        default: begin
          pins_d.en    = 1'b1;
          pins_d.run   = 1'b0;
          last_drive_d = DRV_BRAKE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_target_q  <= '0;
      stall_timeout_q <= STALL_TIMEOUT_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_CYCLE_TARGET) begin
        cycle_target_q <= cfg_i.data[TargetW-1:0];
      end else begin
        stall_timeout_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q    <= 1'b0;
      dir_flag_q   <= DRV_BRAKE;
      last_drive_q <= DRV_BRAKE;
      stall_q      <= '0;
      rev_q        <= '0;
      pins_q       <= '0;
      out_valid_q  <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      if (in_acc) begin
        running_q    <= running_d;
        dir_flag_q   <= dir_flag_d;
        last_drive_q <= last_drive_d;
        stall_q      <= stall_d;
        rev_q        <= rev_d;
        pins_q       <= pins_d;
        done_q       <= done_d;
        out_valid_q  <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The state registers hold exactly what the last result reports.
  assign out_o.valid            = out_valid_q;
  assign out_o.enable_pin       = pins_q.en;
  assign out_o.direction_pin    = pins_q.dir;
  assign out_o.run_pin          = pins_q.run;
  assign out_o.done_res         = done_q;
  assign out_o.travel_direction = dir_flag_q;
  assign out_o.sweep_count      = rev_q;

`ifndef ASSERT_OFF
  // A stopped sequencer always has the brake as its last drive state.
  a_stop_brakes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_q |-> last_drive_q == DRV_BRAKE)
    else $error("stopped but drive state is not brake");

  // A done result always shows the motor braked and the sequencer stopped.
  a_done_braked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && done_q |-> !pins_q.run && !running_q)
    else $error("done reported while motor still driven");

  // Only a finished limited run may lower the reversal count.
  a_rev_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.opcode != OP_RUN_LIMITED |=> rev_q >= $past(rev_q))
    else $error("reversal count went down outside a limited run");

  // An empty output register never blocks the input.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty output register");
`endif

endmodule
